>>> sv/touch_keypad_switch_io_device_macros.svh
// ----------------------------------------------------------------------------
// touch keypad / switch io device assertion macros
// shared assertion wrappers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEYPAD_SWITCH_IO_DEVICE_MACROS_SVH
`define TOUCH_KEYPAD_SWITCH_IO_DEVICE_MACROS_SVH

// concurrent check under the block clock and reset
`define TKSIO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication check: when cond holds, prop must hold in the same cycle
`define TKSIO_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle check: when cond holds, prop must hold in the following cycle
`define TKSIO_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/tksio_pkg.sv
// ----------------------------------------------------------------------------
// tksio_pkg
// shared types and constants of the touch keypad / switch io device
// ----------------------------------------------------------------------------
package tksio_pkg;

    // digit storage
    localparam int MAX_DIGITS     = 8;
    localparam int DEF_NUM_DIGITS = 8;

    // item function codes
    localparam logic [1:0] FUNC_TOUCH = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // bus register addresses
    localparam logic [2:0] ADDR_SWITCH = 3'd0;
    localparam logic [2:0] ADDR_KEYMAT = 3'd1;
    localparam logic [2:0] ADDR_DIGSEL = 3'd2;
    localparam logic [2:0] ADDR_SEGDAT = 3'd3;
    localparam logic [2:0] ADDR_BAR1   = 3'd4;
    localparam logic [2:0] ADDR_BAR2   = 3'd5;

    // touch grid geometry in pixels
    localparam int KEY_LEFT = 113;
    localparam int KEY_TOP  = 37;
    localparam int SW_LEFT  = 27;
    localparam int SW_TOP   = 67;
    localparam int CELL     = 30;

    // keypad row select codes
    localparam logic [3:0] ROW_SEL0 = 4'b0001;
    localparam logic [3:0] ROW_SEL1 = 4'b0010;
    localparam logic [3:0] ROW_SEL2 = 4'b0100;
    localparam logic [3:0] ROW_SEL3 = 4'b1000;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the item and register its result
    } t_dp_cmd;

endpackage

>>> sv/tksio_ctrl.sv
// ----------------------------------------------------------------------------
// tksio_ctrl
// sequencer: accept one item, execute it, then hold the result until taken
// ----------------------------------------------------------------------------
module tksio_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tksio_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;

    // next state
    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_EXEC;
                    n_in_ready = 1'b0;
                end
            end
            S_EXEC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                    n_in_ready  = 1'b1;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
                n_in_ready  = 1'b1;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = i_in_valid && r_in_ready;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

>>> sv/tksio_datapath.sv
// ----------------------------------------------------------------------------
// tksio_datapath
// item capture, touch hit test, bus register file and result register
// ----------------------------------------------------------------------------
module tksio_datapath #(
    parameter int NUM_DIGITS = tksio_pkg::DEF_NUM_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tksio_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_touch_x,
    input  logic [7:0]         i_touch_y,
    input  logic [2:0]         i_reg_addr,
    input  logic [7:0]         i_write_data,
    output logic [7:0]         o_read_data,
    output logic [63:0]        o_segment_image,
    output logic [15:0]        o_bar_image
);

    // captured item
    logic [1:0] r_func;
    logic [7:0] r_x;
    logic [7:0] r_y;
    logic [2:0] r_addr;
    logic [7:0] r_wdata;

    // device state
    logic [15:0] r_key_bits;
    logic [3:0]  r_switch_bits;
    logic [7:0]  r_digit_mask;
    logic [3:0]  r_row_sel;
    logic [7:0]  r_digit [NUM_DIGITS];
    logic [7:0]  r_bar1;
    logic [7:0]  r_bar2;
    logic [7:0]  r_read_data;

    // hit test results
    logic [3:0]  key_col_hit;
    logic [3:0]  key_row_hit;
    logic [1:0]  sw_col_hit;
    logic [1:0]  sw_row_hit;
    logic [15:0] keys;
    logic [3:0]  sws;
    logic [3:0]  row_nibble;
    logic [7:0]  rd;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_x     <= i_touch_x;
            r_y     <= i_touch_y;
            r_addr  <= i_reg_addr;
            r_wdata <= i_write_data;
        end
    end

    // inclusive interval compares per grid column and row
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            key_col_hit[c] = ({1'b0, r_x} >= 9'(tksio_pkg::KEY_LEFT + c * tksio_pkg::CELL))
                && ({1'b0, r_x} <= 9'(tksio_pkg::KEY_LEFT + (c + 1) * tksio_pkg::CELL));
            key_row_hit[c] = ({1'b0, r_y} >= 9'(tksio_pkg::KEY_TOP + c * tksio_pkg::CELL))
                && ({1'b0, r_y} <= 9'(tksio_pkg::KEY_TOP + (c + 1) * tksio_pkg::CELL));
        end
        for (int c = 0; c < 2; c++) begin
            sw_col_hit[c] = ({1'b0, r_x} >= 9'(tksio_pkg::SW_LEFT + c * tksio_pkg::CELL))
                && ({1'b0, r_x} <= 9'(tksio_pkg::SW_LEFT + (c + 1) * tksio_pkg::CELL));
            sw_row_hit[c] = ({1'b0, r_y} >= 9'(tksio_pkg::SW_TOP + c * tksio_pkg::CELL))
                && ({1'b0, r_y} <= 9'(tksio_pkg::SW_TOP + (c + 1) * tksio_pkg::CELL));
        end
        // key bit 4*row+col, switch bit 2*col+row
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                keys[4 * r + c] = key_row_hit[r] && key_col_hit[c];
            end
        end
        for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 2; r++) begin
                sws[2 * c + r] = sw_col_hit[c] && sw_row_hit[r];
            end
        end
    end

    // selected keypad row, zero when selection is not one-hot
    always_comb begin
        case (r_row_sel)
            tksio_pkg::ROW_SEL0: row_nibble = r_key_bits[3:0];
            tksio_pkg::ROW_SEL1: row_nibble = r_key_bits[7:4];
            tksio_pkg::ROW_SEL2: row_nibble = r_key_bits[11:8];
            tksio_pkg::ROW_SEL3: row_nibble = r_key_bits[15:12];
            default:             row_nibble = 4'd0;
        endcase
    end

    // bus read mux
    always_comb begin
        rd = 8'd0;
        if (r_func == tksio_pkg::FUNC_READ) begin
            case (r_addr)
                tksio_pkg::ADDR_SWITCH: rd = {4'd0, r_switch_bits};
                tksio_pkg::ADDR_KEYMAT: rd = {4'd0, row_nibble};
                default:                rd = 8'd0;
            endcase
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits    <= 16'd0;
            r_switch_bits <= 4'd0;
            r_digit_mask  <= 8'd0;
            r_row_sel     <= 4'd0;
            r_bar1        <= 8'd0;
            r_bar2        <= 8'd0;
            r_read_data   <= 8'd0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digit[k] <= 8'd0;
            end
        end else if (i_cmd.exec) begin
            r_read_data <= rd;
            if (r_func == tksio_pkg::FUNC_TOUCH) begin
                r_key_bits    <= keys;
                r_switch_bits <= sws;
            end else if (r_func == tksio_pkg::FUNC_WRITE) begin
                case (r_addr)
                    tksio_pkg::ADDR_KEYMAT: r_row_sel    <= r_wdata[7:4];
                    tksio_pkg::ADDR_DIGSEL: r_digit_mask <= r_wdata;
                    tksio_pkg::ADDR_SEGDAT: begin
                        for (int k = 0; k < NUM_DIGITS; k++) begin
                            if (r_digit_mask[k]) begin
                                r_digit[k] <= r_wdata;
                            end
                        end
                    end
                    tksio_pkg::ADDR_BAR1:   r_bar1 <= r_wdata;
                    tksio_pkg::ADDR_BAR2:   r_bar2 <= r_wdata;
                    default: ;
                endcase
            end
        end
    end

    // latched display images
    for (genvar k = 0; k < tksio_pkg::MAX_DIGITS; k++) begin : g_seg
        if (k < NUM_DIGITS) begin : g_used
            assign o_segment_image[8 * k +: 8] = r_digit[k];
        end else begin : g_unused
            assign o_segment_image[8 * k +: 8] = 8'd0;
        end
    end

    assign o_bar_image = {r_bar2, r_bar1};
    assign o_read_data = r_read_data;

endmodule

>>> sv/touch_keypad_switch_io_device.sv
// Result: valid once the controller has moved through S_EXEC into S_OUT after the
// accept; held until taken. The controller sequences one item at a time through
// the datapath, so a new item is accepted only after the last result is taken.
// Reset: synchronous active-low i_rst_n clears keys, switches, selects, digit
// and bar patterns and the result register; ready is high from the first reset edge.
// ----------------------------------------------------------------------------
// touch_keypad_switch_io_device
// top level: touch hit test into keypad/switch bits plus a small bus register
// file for segment digits, bar LEDs and keypad row scan
// ----------------------------------------------------------------------------
`include "touch_keypad_switch_io_device_macros.svh"

module touch_keypad_switch_io_device #(
    parameter int NUM_DIGITS = tksio_pkg::DEF_NUM_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_touch_x,
    input  logic [7:0]  i_touch_y,
    input  logic [2:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [63:0] o_segment_image,
    output logic [15:0] o_bar_image
);

    tksio_pkg::t_dp_cmd cmd;
    logic               in_take;

    // sequencer
    tksio_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath
    tksio_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_func),
        .i_touch_x       (i_touch_x),
        .i_touch_y       (i_touch_y),
        .i_reg_addr      (i_reg_addr),
        .i_write_data    (i_write_data),
        .o_read_data     (o_read_data),
        .o_segment_image (o_segment_image),
        .o_bar_image     (o_bar_image)
    );

    // input item taken this cycle
    assign in_take = i_in_valid && o_in_ready;

    // checks
    `TKSIO_ASSERT(a_one_in_flight, !(o_out_valid && o_in_ready), "ready while result pending")
    `TKSIO_ASSERT_NEXT(a_accept_blocks, in_take, !o_in_ready && !o_out_valid, "busy after accept")
    `TKSIO_ASSERT_IMP(a_read_nibble, o_out_valid, o_read_data[7:4] == 4'd0, "upper nibble set")

endmodule
